// ===== hdl/pid_pmd_pkg.sv =====
package pid_pmd_pkg;

   // PWM duty resolution
   localparam int DutyBits = 13;

   // Gain register width and reset values
   localparam int GainBits = 10;
   localparam logic [GainBits-1:0] KpReset = 10'd25;
   localparam logic [GainBits-1:0] KiReset = 10'd0;
   localparam logic [GainBits-1:0] KdReset = 10'd0;

   // Configuration register indexes
   localparam int CsrIndexBits = 2;
   localparam logic [CsrIndexBits-1:0] CsrGainProportional = 2'd0;
   localparam logic [CsrIndexBits-1:0] CsrGainIntegral     = 2'd1;
   localparam logic [CsrIndexBits-1:0] CsrGainDerivative   = 2'd2;

   // Arithmetic widths
   localparam int ErrBits   = 17;
   localparam int IntegBits = 32;
   localparam int DerivBits = 18;
   localparam int ProdPBits = GainBits + 1 + ErrBits;
   localparam int ProdIBits = GainBits + 1 + IntegBits;
   localparam int ProdDBits = GainBits + 1 + DerivBits;
   localparam int DriveBits = ProdIBits + 2;

   typedef struct packed {
      logic signed [15:0] target_position;
      logic signed [15:0] current_position;
   } req_type;

   typedef struct packed {
      logic [DutyBits-1:0] pwm_duty;
      logic                motor_direction;
   } rsp_type;

endpackage

// ===== hdl/pid_position_motor_drive.sv =====
// A beat passes the stage-1, stage-2 and result registers before its response is
// valid. Throughput: one beat per cycle without back-pressure; three register
// stages (error/integral, multiply, sum and clamp) each hold one beat and advance
// independently under back-pressure. Reset (synchronous, active high) empties the
// pipeline, clears the error integral and previous error, loads kp = 25, ki = 0, kd = 0.
module pid_position_motor_drive (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  pid_pmd_pkg::req_type                    req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output pid_pmd_pkg::rsp_type                    rsp_data,
   input  logic                                    csr_we,
   input  logic [pid_pmd_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [pid_pmd_pkg::GainBits-1:0]        csr_wdata
);

   localparam int EB = pid_pmd_pkg::ErrBits;
   localparam int IB = pid_pmd_pkg::IntegBits;
   localparam int DB = pid_pmd_pkg::DerivBits;
   localparam int GB = pid_pmd_pkg::GainBits;
   localparam int PPB = pid_pmd_pkg::ProdPBits;
   localparam int PIB = pid_pmd_pkg::ProdIBits;
   localparam int PDB = pid_pmd_pkg::ProdDBits;
   localparam int VB = pid_pmd_pkg::DriveBits;
   localparam int QB = pid_pmd_pkg::DutyBits;

   // Gain registers
   logic [GB-1:0] kp_ff, ki_ff, kd_ff;

   // Controller state, also the stage-1 payload of the newest beat
   logic signed [IB-1:0] error_integral_ff, error_integral_in;
   logic signed [EB-1:0] previous_error_ff, previous_error_in;
   logic signed [DB-1:0] s1_deriv_ff, s1_deriv_in;
   logic                 s1_valid_ff;

   // Stage 2: products and direction
   logic signed [PPB-1:0] s2_prop_ff, s2_prop_in;
   logic signed [PIB-1:0] s2_integ_ff, s2_integ_in;
   logic signed [PDB-1:0] s2_deriv_ff, s2_deriv_in;
   logic                  s2_dir_ff, s2_dir_in;
   logic                  s2_valid_ff;

   // Stage 3: result register
   pid_pmd_pkg::rsp_type rsp_ff, rsp_in;
   logic                 rsp_valid_ff;

   logic en1, en2, en3, accept;
   logic signed [EB-1:0]   err;
   logic signed [IB:0]     integ_sum;
   logic signed [VB-1:0]   drive;
   logic        [VB-1:0]   mag;

   // Stage enables: a stage loads when its successor has room
   assign en3 = !rsp_valid_ff || rsp_ready;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_ready = en1;
   assign accept = req_valid && en1;

   // Gain writes
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= pid_pmd_pkg::KpReset;
         ki_ff <= pid_pmd_pkg::KiReset;
         kd_ff <= pid_pmd_pkg::KdReset;
      end else if (csr_we) begin
         unique case (csr_index)
            pid_pmd_pkg::CsrGainProportional: kp_ff <= csr_wdata;
            pid_pmd_pkg::CsrGainIntegral:     ki_ff <= csr_wdata;
            pid_pmd_pkg::CsrGainDerivative:   kd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage 1: error, saturating integral, derivative
   always_comb begin
      err = EB'(req_data.current_position) - EB'(req_data.target_position);
      integ_sum = (IB+1)'(error_integral_ff) + (IB+1)'(err);
      if (integ_sum[IB] != integ_sum[IB-1]) begin
         error_integral_in = integ_sum[IB] ? {1'b1, {(IB-1){1'b0}}}
                                           : {1'b0, {(IB-1){1'b1}}};
      end else begin
         error_integral_in = integ_sum[IB-1:0];
      end
      previous_error_in = err;
      s1_deriv_in = DB'(err) - DB'(previous_error_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_integral_ff <= '0;
         previous_error_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            error_integral_ff <= error_integral_in;
            previous_error_ff <= previous_error_in;
         end
         if (en1) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_deriv_ff <= s1_deriv_in;
      end
   end

   // Stage 2: gain multiplies
   always_comb begin
      s2_prop_in  = $signed({1'b0, kp_ff}) * previous_error_ff;
      s2_integ_in = $signed({1'b0, ki_ff}) * error_integral_ff;
      s2_deriv_in = $signed({1'b0, kd_ff}) * s1_deriv_ff;
      s2_dir_in   = !previous_error_ff[EB-1] && (previous_error_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && s1_valid_ff) begin
         s2_prop_ff  <= s2_prop_in;
         s2_integ_ff <= s2_integ_in;
         s2_deriv_ff <= s2_deriv_in;
         s2_dir_ff   <= s2_dir_in;
      end
   end

   // Stage 3: sum, magnitude, clamp to duty range
   always_comb begin
      drive = VB'(s2_prop_ff) + VB'(s2_integ_ff) - VB'(s2_deriv_ff);
      mag = drive[VB-1] ? VB'(-drive) : VB'(drive);
      if (mag[VB-1:QB] != '0) begin
         rsp_in.pwm_duty = '1;
      end else begin
         rsp_in.pwm_duty = mag[QB-1:0];
      end
      rsp_in.motor_direction = s2_dir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3 && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // An accepted beat always lands in stage 1
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted beat not held in stage 1");

   // Previous error tracks the error of the last accepted beat
   a_prev_error: assert property (@(posedge clock) disable iff (reset)
      accept |=> previous_error_ff == $past(err))
      else $error("previous error not updated from accepted beat");

   // Direction follows the sign of the stage-1 error
   a_direction: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && en2) |=>
         s2_valid_ff && (s2_dir_ff == ($past(previous_error_ff) > 0)))
      else $error("direction does not match error sign");

   // Full pipeline with a stalled output must refuse input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input accepted while pipeline is full");
`endif

endmodule
